// ----- rtl/core/cahe_pkg.sv -----
// Shared types and constants for the card answer hash engine.
package cahe_pkg;

    localparam int KEY_WORDS   = 7;
    localparam int KEY_BYTES   = 56;
    localparam int REQ_LEN     = 32;
    localparam int ANS_LEN     = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int WIN_LEN     = 16;

    localparam int HEAD_ROUNDS = 27;
    localparam int SIG_BYTES   = 4;
    localparam int TAIL_ROUNDS = 64;

    localparam int KEY_IDX_W = 3;
    localparam int REQ_IDX_W = 5;

    localparam logic [7:0] SHORT_MASK  = 8'he0;
    localparam logic [7:0] SHORT_CODE  = 8'hc0;
    localparam logic [7:0] BLOCK_MASK  = 8'hf0;
    localparam logic [7:0] BLOCK_CODE  = 8'ha0;
    localparam logic [7:0] LAST_MASK   = 8'h0f;
    localparam logic [7:0] WIN24_LIMIT = 8'h3a;
    localparam logic [7:0] WIN8_LIMIT  = 8'h32;
    localparam logic [7:0] SHORT_ANS0  = 8'h01;

    typedef enum logic [1:0] {
        WIN_0  = 2'd0,
        WIN_8  = 2'd1,
        WIN_24 = 2'd2
    } win_sel_t;

    typedef struct packed {
        logic     bank;
        logic     short_ans;
        win_sel_t win;
        logic     blocked;
        logic     sum_bad;
    } job_t;

    typedef logic [KEY_BYTES-1:0][7:0] key_table_t;

endpackage

// ----- rtl/core/cahe_front.sv -----
// Request intake: byte store in two banks, byte sum and request classification.
module cahe_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    output logic                job_push,
    output cahe_pkg::job_t      job_out,
    input  logic                job_release,
    input  logic [cahe_pkg::REQ_IDX_W:0] rd_addr,
    output logic [7:0]          rd_data
);

    logic [cahe_pkg::REQ_IDX_W-1:0] count_reg, count_next;
    logic                           bank_reg, bank_next;
    logic [7:0]                     sum_reg, sum_next;
    logic [1:0]                     outst_reg, outst_next;
    logic [7:0]                     byte0_reg, byte1_reg, byte6_reg;
    logic [7:0]                     req_mem [2*cahe_pkg::REQ_LEN];
    logic [7:0]                     rd_data_reg;
    logic                           accept;
    logic                           last_beat;
    logic [7:0]                     sum_full;

    assign s_tready  = (outst_reg != 2'(cahe_pkg::QUEUE_DEPTH));
    assign accept    = s_tvalid && s_tready;
    assign last_beat = accept && (count_reg == cahe_pkg::REQ_IDX_W'(cahe_pkg::REQ_LEN - 1));
    assign sum_full  = sum_reg + s_tdata;
    assign rd_data   = rd_data_reg;
    assign job_push  = last_beat;

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_mem[{bank_reg, count_reg}] <= s_tdata;
        end
        rd_data_reg <= req_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (accept && count_reg == cahe_pkg::REQ_IDX_W'(0)) begin
            byte0_reg <= s_tdata;
        end
        if (accept && count_reg == cahe_pkg::REQ_IDX_W'(1)) begin
            byte1_reg <= s_tdata;
        end
        if (accept && count_reg == cahe_pkg::REQ_IDX_W'(6)) begin
            byte6_reg <= s_tdata;
        end
    end

    always_comb begin
        job_out.bank      = bank_reg;
        job_out.short_ans = (byte0_reg & cahe_pkg::SHORT_MASK) == cahe_pkg::SHORT_CODE;
        job_out.blocked   = (byte6_reg & cahe_pkg::BLOCK_MASK) == cahe_pkg::BLOCK_CODE;
        job_out.sum_bad   = (sum_full != 8'h00);
        if (byte1_reg > cahe_pkg::WIN24_LIMIT) begin
            job_out.win = cahe_pkg::WIN_24;
        end else if (byte1_reg > cahe_pkg::WIN8_LIMIT) begin
            job_out.win = cahe_pkg::WIN_8;
        end else begin
            job_out.win = cahe_pkg::WIN_0;
        end
    end

    always_comb begin
        count_next = count_reg;
        bank_next  = bank_reg;
        sum_next   = sum_reg;
        if (accept) begin
            count_next = count_reg + 1'b1;
            sum_next   = sum_full;
        end
        if (last_beat) begin
            bank_next = ~bank_reg;
            sum_next  = 8'h00;
        end
        outst_next = outst_reg;
        case ({job_push, job_release})
            2'b10:   outst_next = outst_reg + 2'd1;
            2'b01:   outst_next = outst_reg - 2'd1;
            default: outst_next = outst_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            bank_reg  <= 1'b0;
            sum_reg   <= 8'h00;
            outst_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
            bank_reg  <= bank_next;
            sum_reg   <= sum_next;
            outst_reg <= outst_next;
        end
    end

endmodule

// ----- rtl/core/cahe_queue.sv -----
// Two-entry job queue between intake and hash sequencer.
module cahe_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cahe_pkg::job_t job_in,
    input  logic           pop,
    output logic           job_valid,
    output cahe_pkg::job_t job_out
);

    cahe_pkg::job_t entry_reg [cahe_pkg::QUEUE_DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;

    assign job_valid = (fill_reg != 2'd0);
    assign job_out   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- rtl/core/cahe_back.sv -----
// Hash sequencer: keyed mixing rounds over an eight-byte ring and answer output.
module cahe_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cahe_pkg::key_table_t         key_tab,
    input  logic                         job_valid,
    input  cahe_pkg::job_t               job,
    output logic                         job_pop,
    output logic [cahe_pkg::REQ_IDX_W:0] rd_addr,
    input  logic [7:0]                   rd_data,
    output logic                         job_release,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,
    output logic [2:0]                   m_tuser,
    output logic                         m_tlast
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PRIME = 7'b0000010,
        ST_ROUND = 7'b0000100,
        ST_SIG   = 7'b0001000,
        ST_TAIL  = 7'b0010000,
        ST_ALIGN = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [7:0]         ring_reg [cahe_pkg::ANS_LEN];
    logic [7:0]         ring_next [cahe_pkg::ANS_LEN];
    logic [7:0]         ring_mix [cahe_pkg::ANS_LEN];
    logic [7:0]         ring_rot [cahe_pkg::ANS_LEN];
    logic [5:0]         cnt_reg, cnt_next;
    logic [1:0]         ph_reg, ph_next;
    logic [cahe_pkg::REQ_IDX_W-1:0] idx_reg, idx_next;
    logic               bank_reg, bank_next;
    cahe_pkg::win_sel_t win_reg, win_next;
    logic [7:0]         carry_reg, carry_next;
    logic               sig_bad_reg, sig_bad_next;
    logic               sum_bad_reg, sum_bad_next;
    logic               blocked_reg, blocked_next;
    logic               short_reg, short_next;
    logic [2:0]         beat_reg, beat_next;

    logic               m_tvalid_reg;
    logic [7:0]         m_tdata_reg;
    logic [2:0]         m_tuser_reg;
    logic               m_tlast_reg;
    logic               out_load;
    logic               out_free;
    logic [7:0]         out_byte;

    logic [7:0]         hi_win [cahe_pkg::WIN_LEN];
    logic [7:0]         lo_win [cahe_pkg::WIN_LEN];
    logic [7:0]         feed;
    logic [7:0]         mix_v;
    logic [7:0]         key_sum;
    logic [7:0]         c_not;
    logic [7:0]         c_rol;
    logic [7:0]         c_add;
    logic [7:0]         c_ror;

    assign rd_addr  = {bank_reg, idx_reg};
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        for (int j = 0; j < cahe_pkg::WIN_LEN; j++) begin
            unique case (win_reg)
                cahe_pkg::WIN_8: begin
                    hi_win[j] = key_tab[8 + j];
                    lo_win[j] = key_tab[8 + cahe_pkg::WIN_LEN + j];
                end
                cahe_pkg::WIN_24: begin
                    hi_win[j] = key_tab[24 + j];
                    lo_win[j] = key_tab[24 + cahe_pkg::WIN_LEN + j];
                end
                default: begin
                    hi_win[j] = key_tab[j];
                    lo_win[j] = key_tab[cahe_pkg::WIN_LEN + j];
                end
            endcase
        end
    end

    always_comb begin
        feed    = (state_reg == ST_SIG) ? carry_reg : rd_data;
        mix_v   = ring_reg[0] ^ feed;
        key_sum = hi_win[mix_v[7:4]] + lo_win[mix_v[3:0]];
        c_not   = ~key_sum;
        c_rol   = {c_not[6:0], c_not[7]};
        c_add   = c_rol + feed;
        c_ror   = {c_add[2:0], c_add[7:3]};
        for (int j = 0; j < cahe_pkg::ANS_LEN - 1; j++) begin
            ring_mix[j] = ring_reg[j + 1];
            ring_rot[j] = ring_reg[j + 1];
        end
        ring_mix[0] = ring_reg[1] ^ c_ror;
        ring_mix[cahe_pkg::ANS_LEN - 1] = mix_v;
        ring_rot[cahe_pkg::ANS_LEN - 1] = ring_reg[0];
    end

    always_comb begin
        out_byte = (sig_bad_reg || (blocked_reg && !short_reg)) ? 8'h00 : ring_reg[0];
        if (beat_reg == 3'(cahe_pkg::ANS_LEN - 1)) begin
            out_byte = out_byte & cahe_pkg::LAST_MASK;
        end
    end

    always_comb begin
        state_next   = state_reg;
        ring_next    = ring_reg;
        cnt_next     = cnt_reg;
        ph_next      = ph_reg;
        idx_next     = idx_reg;
        bank_next    = bank_reg;
        win_next     = win_reg;
        carry_next   = carry_reg;
        sig_bad_next = sig_bad_reg;
        sum_bad_next = sum_bad_reg;
        blocked_next = blocked_reg;
        short_next   = short_reg;
        beat_next    = beat_reg;
        job_pop      = 1'b0;
        job_release  = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_pop      = 1'b1;
                    bank_next    = job.bank;
                    win_next     = job.win;
                    short_next   = job.short_ans;
                    blocked_next = job.blocked;
                    sum_bad_next = job.sum_bad && !job.short_ans;
                    sig_bad_next = 1'b0;
                    carry_next   = 8'h00;
                    cnt_next     = 6'd0;
                    ph_next      = 2'd0;
                    idx_next     = '0;
                    beat_next    = 3'd0;
                    for (int j = 0; j < cahe_pkg::ANS_LEN; j++) begin
                        ring_next[j] = 8'h00;
                    end
                    if (job.short_ans) begin
                        ring_next[0] = cahe_pkg::SHORT_ANS0;
                        job_release  = 1'b1;
                        state_next   = ST_OUT;
                    end else begin
                        state_next = ST_PRIME;
                    end
                end
            end
            ST_PRIME: begin
                idx_next   = idx_reg + 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                ring_next = ring_mix;
                if (cnt_reg == 6'(cahe_pkg::HEAD_ROUNDS - 1)) begin
                    cnt_next   = 6'd0;
                    state_next = ST_SIG;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SIG: begin
                if (ph_reg == 2'd2) begin
                    ph_next      = 2'd0;
                    ring_next    = ring_rot;
                    carry_next   = rd_data;
                    sig_bad_next = sig_bad_reg || (ring_reg[0] != rd_data);
                    if (cnt_reg == 6'(cahe_pkg::SIG_BYTES - 1)) begin
                        cnt_next   = 6'd0;
                        state_next = ST_TAIL;
                    end else begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end else begin
                    ring_next = ring_mix;
                    ph_next   = ph_reg + 2'd1;
                    if (ph_reg == 2'd1 && cnt_reg != 6'(cahe_pkg::SIG_BYTES - 1)) begin
                        idx_next = idx_reg + 1'b1;
                    end else if (ph_reg == 2'd1) begin
                        idx_next = cahe_pkg::REQ_IDX_W'(cahe_pkg::REQ_LEN - 1);
                    end
                end
            end
            ST_TAIL: begin
                ring_next = ring_mix;
                if (cnt_reg == 6'(cahe_pkg::TAIL_ROUNDS - 1)) begin
                    cnt_next   = 6'd0;
                    state_next = ST_ALIGN;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_ALIGN: begin
                ring_next   = ring_rot;
                job_release = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    ring_next = ring_rot;
                    beat_next = beat_reg + 3'd1;
                    if (beat_reg == 3'(cahe_pkg::ANS_LEN - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        ring_reg    <= ring_next;
        cnt_reg     <= cnt_next;
        ph_reg      <= ph_next;
        idx_reg     <= idx_next;
        bank_reg    <= bank_next;
        win_reg     <= win_next;
        carry_reg   <= carry_next;
        sig_bad_reg <= sig_bad_next;
        sum_bad_reg <= sum_bad_next;
        blocked_reg <= blocked_next;
        short_reg   <= short_next;
        beat_reg    <= beat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_load) begin
            m_tdata_reg <= out_byte;
            m_tuser_reg <= {!short_reg && !sig_bad_reg, sum_bad_reg, sig_bad_reg};
            m_tlast_reg <= (beat_reg == 3'(cahe_pkg::ANS_LEN - 1));
        end
    end

    a_pop_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> (state_reg == ST_IDLE && job_valid))
        else $error("job taken outside idle or from an empty queue");

    a_tail_addr : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAIL) |-> (idx_reg == cahe_pkg::REQ_IDX_W'(cahe_pkg::REQ_LEN - 1)))
        else $error("tail rounds not fed from the last request byte");

    a_last_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && beat_reg == 3'(cahe_pkg::ANS_LEN - 1)) |=> (state_reg == ST_IDLE))
        else $error("sequencer not idle after the last answer beat");

    a_release_once : assert property (@(posedge aclk) disable iff (!aresetn)
        job_release |=> !job_release)
        else $error("request bank released twice");

endmodule

// ----- rtl/core/card_answer_hash_engine.sv -----
// Top level of the card answer hash engine: key registers, intake, queue and sequencer.
//
//  channel   dir   beat                                   handshake
//  s_        in    tdata[7:0] request byte                tvalid/tready
//  m_        out   tdata[7:0] answer byte, tuser[2:0],    tvalid/tready
//                  tlast on the eighth answer beat
//  cfg_      in    cfg_index selects key word 0..6        cfg_we, no wait
//
//  A request is 32 input beats at up to one per cycle, into one of two request banks.
//  Hashing runs a priming step, 27 head rounds, a check of 4 signature bytes, 64 tail
//  rounds and an alignment step on the single mixing unit; a short-answer request
//  skips it. Answers leave at one beat per cycle while m_tready allows.
//  The next request is taken while one is hashed; intake stalls only with two pending.
//  aresetn is synchronous and clears the control state and the key words.
module card_answer_hash_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] request_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] answer_byte
    output logic [2:0]  m_tuser,   // [0] signature_bad, [1] sum_bad, [2] key_accepted
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    logic [63:0]          key_word_reg [cahe_pkg::KEY_WORDS];
    cahe_pkg::key_table_t key_tab;
    cahe_pkg::job_t       push_job;
    cahe_pkg::job_t       head_job;
    logic                 job_push;
    logic                 job_pop;
    logic                 job_valid;
    logic                 job_release;
    logic [cahe_pkg::REQ_IDX_W:0] rd_addr;
    logic [7:0]           rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cahe_pkg::KEY_WORDS; i++) begin
                key_word_reg[i] <= 64'd0;
            end
        end else if (cfg_we && cfg_index < cahe_pkg::KEY_IDX_W'(cahe_pkg::KEY_WORDS)) begin
            key_word_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_comb begin
        for (int i = 0; i < cahe_pkg::KEY_BYTES; i++) begin
            key_tab[i] = key_word_reg[i / 8][(i % 8) * 8 +: 8];
        end
    end

    cahe_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .job_push    (job_push),
        .job_out     (push_job),
        .job_release (job_release),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    cahe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .job_in    (push_job),
        .pop       (job_pop),
        .job_valid (job_valid),
        .job_out   (head_job)
    );

    cahe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .key_tab     (key_tab),
        .job_valid   (job_valid),
        .job         (head_job),
        .job_pop     (job_pop),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .job_release (job_release),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
